@@ hw/rtl/bmpup_pkg.sv @@
// Shared types and constants for the row pixel upscaler.
package bmpup_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_SCALE_DEF = 16;

	localparam int CFG_DATA_W = 13;
	localparam int COPIES_W   = 7;

	localparam logic REG_ROW_WIDTH    = 1'b0;
	localparam logic REG_SCALE_FACTOR = 1'b1;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [23:0]         pix;
		logic                from_mem;
		logic                ends_row;
		logic [1:0]          pad;
		logic [COPIES_W-1:0] copies;
		logic                dropped;
	} job_t;

endpackage

@@ hw/rtl/bmpup_line_mem.sv @@
// Line store: one write port, one read port with registered read data.
module bmpup_line_mem #(
	parameter int DEPTH = bmpup_pkg::MAX_WIDTH_DEF,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bmpup_ctrl.sv @@
// Front end: configuration, column and replay state, line store access, job stage.
module bmpup_ctrl #(
	parameter int MAX_WIDTH = bmpup_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = bmpup_pkg::MAX_SCALE_DEF,
	parameter int AW        = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_addr,
	input  logic [bmpup_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             in_cmd,
	input  logic [23:0]                      in_pix,
	input  logic                             job_ready,
	output logic                             job_valid,
	output bmpup_pkg::job_t                  job,
	output logic                             mem_we,
	output logic                             mem_re,
	output logic [AW-1:0]                    mem_addr
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	logic [12:0]     row_width_q;
	logic [4:0]      scale_q;
	logic [AW-1:0]   col_q;
	logic [RW-1:0]   rows_q;
	logic            replaying_q;
	logic            s1_valid_q;
	bmpup_pkg::job_t job_s1;

	logic [WW-1:0]   eff_w;
	logic [SW-1:0]   eff_s;
	logic            ends_row;
	logic [1:0]      pad;
	logic            accept;
	logic            is_push;
	logic            produce;
	logic [RW-1:0]   rows_dec;
	bmpup_pkg::job_t job_next;

	always_comb begin
		if (row_width_q == 13'd0) begin
			eff_w = WW'(1);
		end else if (32'(row_width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(row_width_q);
		end
		if (scale_q == 5'd0) begin
			eff_s = SW'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			eff_s = SW'(MAX_SCALE);
		end else begin
			eff_s = SW'(scale_q);
		end
	end

	assign ends_row = (WW'(col_q) + WW'(1)) >= eff_w;
	// w*s*3 padded to 4 bytes needs (w*s) mod 4 zero bytes
	assign pad      = 2'(2'(eff_w) * 2'(eff_s));

	assign in_ready = !s1_valid_q || job_ready;
	assign accept   = in_valid && in_ready;
	assign is_push  = (in_cmd == bmpup_pkg::CMD_PUSH);
	assign produce  = accept && (is_push || replaying_q);

	assign mem_we   = accept && is_push && !replaying_q;
	assign mem_re   = accept && !is_push && replaying_q;
	assign mem_addr = col_q;

	assign rows_dec = (rows_q != '0) ? RW'(rows_q - RW'(1)) : rows_q;

	always_comb begin
		job_next.pix      = in_pix;
		job_next.from_mem = !is_push;
		job_next.ends_row = ends_row;
		job_next.pad      = pad;
		job_next.copies   = bmpup_pkg::COPIES_W'(eff_s);
		job_next.dropped  = 1'b0;
		if (is_push && replaying_q) begin
			job_next.pix      = '0;
			job_next.from_mem = 1'b0;
			job_next.ends_row = 1'b0;
			job_next.pad      = 2'b00;
			job_next.copies   = bmpup_pkg::COPIES_W'(1);
			job_next.dropped  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 13'd1;
			scale_q     <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				bmpup_pkg::REG_ROW_WIDTH:    row_width_q <= cfg_wdata;
				bmpup_pkg::REG_SCALE_FACTOR: scale_q     <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			rows_q      <= '0;
			replaying_q <= 1'b0;
		end else if (accept) begin
			if (is_push && !replaying_q) begin
				if (ends_row) begin
					col_q <= '0;
					if (eff_s > SW'(1)) begin
						replaying_q <= 1'b1;
						rows_q      <= RW'(eff_s - SW'(1));
					end
				end else begin
					col_q <= AW'(col_q + AW'(1));
				end
			end else if (!is_push && replaying_q) begin
				if (ends_row) begin
					col_q  <= '0;
					rows_q <= rows_dec;
					if (rows_dec == '0) begin
						replaying_q <= 1'b0;
					end
				end else begin
					col_q <= AW'(col_q + AW'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (produce) begin
			s1_valid_q <= 1'b1;
		end else if (job_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			job_s1 <= job_next;
		end
	end

	assign job_valid = s1_valid_q;
	assign job       = job_s1;

endmodule

@@ hw/rtl/bmpup_emit.sv @@
// Output stage: repeats each job's pixel copies times, one word per ready cycle.
module bmpup_emit #(
	parameter int MAX_SCALE = bmpup_pkg::MAX_SCALE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  bmpup_pkg::job_t job,
	input  logic [23:0]     rd_data,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0]     m_axis_tdata,
	output logic            m_axis_tlast,
	output logic [1:0]      m_axis_tuser
);

	localparam int CW = $clog2(MAX_SCALE + 1);

	logic          em_valid_q;
	logic [CW-1:0] em_cnt_q;
	logic [23:0]   em_pix_q;
	logic          em_ends_q;
	logic [1:0]    em_pad_q;
	logic          em_drop_q;

	logic          is_last;
	logic          load;
	logic          row_end;

	assign is_last   = (em_cnt_q == CW'(1));
	assign job_ready = !em_valid_q || (m_axis_tready && is_last);
	assign load      = job_valid && job_ready;
	assign row_end   = em_ends_q && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_cnt_q   <= '0;
		end else if (load) begin
			em_valid_q <= 1'b1;
			em_cnt_q   <= CW'(job.copies);
		end else if (em_valid_q && m_axis_tready) begin
			if (is_last) begin
				em_valid_q <= 1'b0;
			end else begin
				em_cnt_q <= CW'(em_cnt_q - CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_pix_q  <= job.from_mem ? rd_data : job.pix;
			em_ends_q <= job.ends_row;
			em_pad_q  <= job.pad;
			em_drop_q <= job.dropped;
		end
	end

	assign m_axis_tvalid = em_valid_q;
	assign m_axis_tdata  = {6'b0, (row_end ? em_pad_q : 2'b00), em_pix_q};
	assign m_axis_tlast  = row_end;
	assign m_axis_tuser  = {em_drop_q, is_last};

endmodule

@@ hw/rtl/bmp_row_pixel_upscaler.sv @@
// Top level of the nearest-neighbour row pixel upscaler.
// Every pushed pixel or replay tick yields scale_factor output words, one per cycle
// while m_axis_tready is high (one word for a dropped push, none for a tick outside
// replay); the copy counter in the output stage counts these words. With the
// job register full, the next item is taken at the edge where the last copy of the word
// being emitted leaves. An accepted item passes the job register, loaded together with
// the line store read at the accepting edge, and then the output register, which
// takes it once the last copy of the word before it has left and then offers its copies.
// Pixels are written to the line store as they arrive; after a row's last
// pixel, ticks replay the stored row scale_factor-1 times. A push during replay returns
// a single dropped word. The line store needs no clearing after reset.
module bmp_row_pixel_upscaler #(
	parameter int MAX_WIDTH = bmpup_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = bmpup_pkg::MAX_SCALE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_addr,   // 0 row_width, 1 scale_factor
	input  logic [bmpup_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [23:0]                      s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                             s_axis_tuser,  // cmd
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [31:0]                      m_axis_tdata,  // red_out, green_out, blue_out,
	                                                        // pad_bytes, zero fill
	output logic                             m_axis_tlast,  // row_end
	output logic [1:0]                       m_axis_tuser   // last, dropped
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic            job_valid;
	logic            job_ready;
	bmpup_pkg::job_t job;
	logic            mem_we;
	logic            mem_re;
	logic [AW-1:0]   mem_addr;
	logic [23:0]     rd_data;

	bmpup_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser),
		.in_pix(s_axis_tdata),
		.job_ready(job_ready),
		.job_valid(job_valid),
		.job(job),
		.mem_we(mem_we),
		.mem_re(mem_re),
		.mem_addr(mem_addr)
	);

	bmpup_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_line_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_addr),
		.wdata(s_axis_tdata),
		.re(mem_re),
		.raddr(mem_addr),
		.rdata(rd_data)
	);

	bmpup_emit #(
		.MAX_SCALE(MAX_SCALE)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job(job),
		.rd_data(rd_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

`ifndef ASSERT_OFF
	a_drop_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && !m_axis_tlast)
		else $error("dropped word not a lone final word");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("row end on a non-final copy");

	a_pad_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[25:24] != 2'b00) |-> m_axis_tlast)
		else $error("padding away from row end");
`endif

endmodule
